/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, request codes and helpers for the block allocation bitmap.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_MAP_BITS = 1024;
  localparam int BYTE_BITS    = 8;
  localparam int REQ_W        = 2;
  localparam int INDEX_W      = 10;
  localparam int LIMIT_W      = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic access_done;
    logic scan_issue;
    logic scan_finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_done;
  } status_t;

  typedef struct packed {
    logic       found;
    logic [2:0] pos;
  } first_free_t;

  // Lowest free position in a byte, most significant bit first.
  function automatic first_free_t first_free(input logic [BYTE_BITS-1:0] cand);
    first_free_t res;
    res.found = 1'b0;
    res.pos   = 3'd0;
    for (int j = BYTE_BITS - 1; j >= 0; j--) begin
      if (cand[BYTE_BITS-1-j]) begin
        res.found = 1'b1;
        res.pos   = 3'(j);
      end
    end
    return res;
  endfunction

endpackage

/* hdl/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Block allocation bitmap with bit read, bit write and a first-free search.
//
// Channel   Ports                                    Handshake
// request   req_type, bit_index, bit_value           accepted when start & !busy
// result    read_bit, free_found, free_index         valid for one cycle with done
// config    search_limit                             written when search_limit_we
//
// A read or write request holds busy while in ST_ACCESS; its result is registered
// and appears with done after that state. A find request reads one bitmap
// byte per cycle through the single memory read port. It examines at least one
// byte and at most ceil(min(limit, MAP_BITS) / 8), fewer on an early hit;
// busy stays high through ST_SCAN and done is registered from the last byte.
// After reset a clearing pass zeroes the memory one byte per cycle,
// covering all (MAP_BITS + 7) / 8 bytes, with busy high.
// The receiver cannot stall; each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAP_BITS = bba_pkg::DEF_MAP_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bba_pkg::REQ_W-1:0]     req_type,
  input  logic [bba_pkg::INDEX_W-1:0]   bit_index,
  input  logic                          bit_value,
  input  logic                          search_limit_we,
  input  logic [bba_pkg::LIMIT_W-1:0]   search_limit,
  output logic                          done,
  output logic                          read_bit,
  output logic                          free_found,
  output logic [bba_pkg::INDEX_W-1:0]   free_index
);

  bba_pkg::ctl_t    ctl;
  bba_pkg::status_t status;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .ctl      (ctl),
    .busy     (busy)
  );

  bba_datapath #(
    .MAP_BITS (MAP_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .status          (status),
    .req_type        (req_type),
    .bit_index       (bit_index),
    .bit_value       (bit_value),
    .search_limit_we (search_limit_we),
    .search_limit    (search_limit),
    .done            (done),
    .read_bit        (read_bit),
    .free_found      (free_found),
    .free_index      (free_index)
  );

endmodule

/* hdl/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: sequences the clearing pass, bit accesses and the free search.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bba_pkg::REQ_W-1:0]   req_type,
  input  bba_pkg::status_t            status,
  output bba_pkg::ctl_t               ctl,
  output logic                        busy
);

  bba_pkg::state_t state;
  bba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (req_type == bba_pkg::REQ_FIND) ? bba_pkg::ST_SCAN
                                                       : bba_pkg::ST_ACCESS;
        end
      end
      bba_pkg::ST_ACCESS: begin
        state_next = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = bba_pkg::ST_IDLE;
      end
      default: begin
        state_next = bba_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
      end
      bba_pkg::ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      bba_pkg::ST_ACCESS: begin
        ctl.access_done = 1'b1;
      end
      bba_pkg::ST_SCAN: begin
        ctl.scan_issue  = ~status.scan_done;
        ctl.scan_finish = status.scan_done;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

/* hdl/bba_datapath.sv */
// ----------------------------------------------------------------------------
// bba_datapath
// Datapath: bitmap memory, request registers, search limit and result registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MAP_BITS = bba_pkg::DEF_MAP_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::ctl_t                 ctl,
  output bba_pkg::status_t              status,
  input  logic [bba_pkg::REQ_W-1:0]     req_type,
  input  logic [bba_pkg::INDEX_W-1:0]   bit_index,
  input  logic                          bit_value,
  input  logic                          search_limit_we,
  input  logic [bba_pkg::LIMIT_W-1:0]   search_limit,
  output logic                          done,
  output logic                          read_bit,
  output logic                          free_found,
  output logic [bba_pkg::INDEX_W-1:0]   free_index
);

  localparam int STORE_BYTES = (MAP_BITS + bba_pkg::BYTE_BITS - 1) / bba_pkg::BYTE_BITS;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = (AW + 4 > bba_pkg::LIMIT_W) ? AW + 4 : bba_pkg::LIMIT_W;

  logic [bba_pkg::BYTE_BITS-1:0] mem [STORE_BYTES];
  logic [bba_pkg::BYTE_BITS-1:0] rd_data;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 addr;
  logic [AW-1:0]                 data_addr;
  logic                          scan_valid;

  logic [bba_pkg::REQ_W-1:0]     req_q;
  logic [bba_pkg::INDEX_W-1:0]   idx_q;
  logic                          val_q;
  logic                          in_range_q;
  logic [bba_pkg::LIMIT_W-1:0]   limit_q;

  logic [AW-1:0]                 byte_q;
  logic [2:0]                    bit_sel;
  logic [bba_pkg::BYTE_BITS-1:0] bit_mask;
  logic [bba_pkg::BYTE_BITS-1:0] wr_data;
  logic                          wr_en;
  logic                          cur_bit;
  logic                          access_bit;

  logic [CW-1:0]                 lim_eff;
  logic [CW-1:0]                 base;
  logic [CW-1:0]                 diff;
  logic                          below;
  logic                          last_byte;
  logic [bba_pkg::BYTE_BITS-1:0] elig;
  bba_pkg::first_free_t          hit;
  logic [CW-1:0]                 hit_pos;

  // Search limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= bba_pkg::LIMIT_RESET;
    end else if (search_limit_we) begin
      limit_q <= search_limit;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_q      <= req_type;
      idx_q      <= bit_index;
      val_q      <= bit_value;
      in_range_q <= CW'(bit_index) < CW'(MAP_BITS);
    end
  end

  // Shared address counter for the clearing pass and the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      scan_valid <= 1'b0;
    end else begin
      scan_valid <= ctl.scan_issue;
      if (ctl.accept) begin
        addr <= '0;
      end else if (ctl.clear_wr || ctl.scan_issue) begin
        addr <= addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_issue) data_addr <= addr;
  end

  assign status.clear_last = ctl.clear_wr && (addr == AW'(STORE_BYTES - 1));

  // Bitmap memory: one write port, one registered read port.
  assign rd_addr = ctl.accept ? AW'(bit_index[bba_pkg::INDEX_W-1:3]) : addr;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign byte_q   = AW'(idx_q[bba_pkg::INDEX_W-1:3]);
  assign bit_sel  = ~idx_q[2:0];
  assign bit_mask = bba_pkg::BYTE_BITS'(1) << bit_sel;
  assign wr_data  = val_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
  assign wr_en    = ctl.access_done && (req_q == bba_pkg::REQ_WRITE) && in_range_q;

  always_ff @(posedge clk) begin
    if (ctl.clear_wr) begin
      mem[addr] <= '0;
    end else if (wr_en) begin
      mem[byte_q] <= wr_data;
    end
  end

  assign cur_bit = rd_data[bit_sel];

  always_comb begin
    case (req_q)
      bba_pkg::REQ_READ:  access_bit = in_range_q & cur_bit;
      bba_pkg::REQ_WRITE: access_bit = in_range_q & val_q;
      default:            access_bit = 1'b0;
    endcase
  end

  // Free search: examine one returned byte per cycle against the limit.
  assign lim_eff   = (CW'(limit_q) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(limit_q);
  assign base      = CW'({data_addr, 3'b000});
  assign below     = base < lim_eff;
  assign diff      = lim_eff - base;
  assign last_byte = !below || (diff <= CW'(bba_pkg::BYTE_BITS));

  always_comb begin
    if (!below) begin
      elig = '0;
    end else if (diff >= CW'(bba_pkg::BYTE_BITS)) begin
      elig = '1;
    end else begin
      // The positions left below the limit are the top bits of the byte.
      elig = ~(8'hFF >> diff[2:0]);
    end
  end

  assign hit     = bba_pkg::first_free(~rd_data & elig);
  assign hit_pos = CW'({data_addr, hit.pos});

  assign status.scan_done = scan_valid && (hit.found || last_byte);

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.access_done | ctl.scan_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.access_done) begin
      read_bit   <= access_bit;
      free_found <= 1'b0;
      free_index <= '0;
    end else if (ctl.scan_finish) begin
      read_bit   <= 1'b0;
      free_found <= hit.found;
      free_index <= hit.found ? hit_pos[bba_pkg::INDEX_W-1:0] : '0;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_found_no_bit: assert property (@(posedge clk) disable iff (rst)
    (done && free_found) |-> !read_bit)
    else $error("find result carries a read bit");

  a_access_no_scan: assert property (@(posedge clk) disable iff (rst)
    ctl.access_done |-> !scan_valid)
    else $error("bit access overlaps a scan");

  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_wr |-> !wr_en && !scan_valid)
    else $error("request activity during the clearing pass");

endmodule
